>>> rtl/qpnlri_pkg.sv
// qpnlri_pkg: shared widths, codes and transaction types of the qp nlri tlv parser
// no dependencies; used by every other rtl file of the block
package qpnlri_pkg;

  localparam int BYTE_W       = 8;
  localparam int MAX_QP_BITS  = 24;
  localparam int QP_W         = 24;
  localparam int QPLEN_W      = 5;
  localparam int PFX_W        = 32;
  localparam int PFXLEN_W     = 6;
  localparam int PFX_MAX_BITS = 32;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DQPN_TYPE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_TYPE = 1'd1;

  localparam logic [BYTE_W-1:0] DQPN_TYPE_RST   = 8'd1;
  localparam logic [BYTE_W-1:0] PREFIX_TYPE_RST = 8'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FORMAT    = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] dqpn_type;
    logic [BYTE_W-1:0] prefix_type;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              block_end;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [QP_W-1:0]     qp_number;
    logic [QPLEN_W-1:0]  qp_bits;
    logic [PFX_W-1:0]    prefix_addr;
    logic [PFXLEN_W-1:0] prefix_bits;
    logic                last_of_block;
  } res_t;

endpackage

>>> rtl/qpnlri_if.sv
// qpnlri_in_if / qpnlri_out_if: valid/ready channels for raw bytes and parse results
// depends on qpnlri_pkg for field widths
interface qpnlri_in_if;
  logic                         valid;
  logic                         ready;
  logic [qpnlri_pkg::BYTE_W-1:0] data_byte;
  logic                         block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

interface qpnlri_out_if;
  logic                            valid;
  logic                            ready;
  logic [qpnlri_pkg::STATUS_W-1:0] status;
  logic [qpnlri_pkg::QP_W-1:0]     qp_number;
  logic [qpnlri_pkg::QPLEN_W-1:0]  qp_bits;
  logic [qpnlri_pkg::PFX_W-1:0]    prefix_addr;
  logic [qpnlri_pkg::PFXLEN_W-1:0] prefix_bits;
  logic                            last_of_block;

  modport source (output valid, output status, output qp_number, output qp_bits,
                  output prefix_addr, output prefix_bits, output last_of_block,
                  input ready);
  modport sink (input valid, input status, input qp_number, input qp_bits,
                input prefix_addr, input prefix_bits, input last_of_block,
                output ready);
endinterface

>>> rtl/qpnlri_in_stage.sv
// qpnlri_in_stage: input register holding one byte transaction for the parser
// depends on qpnlri_pkg and qpnlri_in_if
module qpnlri_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  qpnlri_in_if.sink            src,
  input  logic                 advance,
  output logic                 item_valid,
  output qpnlri_pkg::in_item_t item
);
  import qpnlri_pkg::*;

  logic take;

  // slot frees up when the parser consumes the held byte
  assign src.ready = !item_valid || advance;
  assign take      = src.valid && src.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (src.ready) begin
      item_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.data_byte <= src.data_byte;
      item.block_end <= src.block_end;
    end
  end

endmodule

>>> rtl/qpnlri_parse.sv
// qpnlri_parse: per-byte tlv parse state and next-state/result logic
// depends on qpnlri_pkg
module qpnlri_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 item_valid,
  input  qpnlri_pkg::in_item_t item,
  input  qpnlri_pkg::cfg_t     cfg,
  output logic                 res_valid,
  output qpnlri_pkg::res_t     res
);
  import qpnlri_pkg::*;

  typedef enum logic [5:0] {
    PH_LEN    = 6'b000001,
    PH_TYPE   = 6'b000010,
    PH_TLEN   = 6'b000100,
    PH_QPVAL  = 6'b001000,
    PH_PFXVAL = 6'b010000,
    PH_SKIP   = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [BYTE_W-1:0]   entry_left;
    logic [BYTE_W-1:0]   tlv_kind;
    logic [BYTE_W-1:0]   tlv_left;
    logic [QPLEN_W-1:0]  tlv_bits;
    logic [1:0]          byte_slot;
    logic [QP_W-1:0]     qp_accum;
    logic [QPLEN_W-1:0]  qp_len;
    logic [PFX_W-1:0]    prefix;
    logic [PFXLEN_W-1:0] pfx_len;
    logic                seen_qp;
    logic                seen_prefix;
    logic                stopped;
  } pstate_t;

  localparam pstate_t PSTATE_RST = '{
    phase: PH_LEN, entry_left: '0, tlv_kind: '0, tlv_left: '0, tlv_bits: '0,
    byte_slot: '0, qp_accum: '0, qp_len: '0, prefix: '0, pfx_len: '0,
    seen_qp: 1'b0, seen_prefix: 1'b0, stopped: 1'b0
  };

  pstate_t           cur;
  pstate_t           cur_next;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] entry_dec;
  logic [BYTE_W-1:0] tlv_dec;
  logic [BYTE_W:0]   val_bytes;
  logic [QP_W-1:0]   qp_shifted;
  logic [QP_W-1:0]   qp_high;
  logic              fmt_err;
  logic              tlv_end;
  logic              emit;
  status_t           code;

  assign b          = item.data_byte;
  assign entry_dec  = cur.entry_left - 8'd1;
  assign tlv_dec    = cur.tlv_left - 8'd1;
  assign val_bytes  = ({1'b0, b} + 9'd7) >> 3;
  assign qp_shifted = {cur.qp_accum[QP_W-BYTE_W-1:0], b};
  // bits at and above the declared length
  assign qp_high    = qp_shifted & ~((QP_W'(1) << cur.tlv_bits) - QP_W'(1));

  always_comb begin
    cur_next = cur;
    fmt_err  = 1'b0;
    tlv_end  = 1'b0;
    emit     = 1'b0;
    code     = ST_OK;

    if (!cur.stopped) begin
      unique case (cur.phase)
        PH_LEN: begin
          cur_next.qp_accum    = '0;
          cur_next.qp_len      = '0;
          cur_next.prefix      = '0;
          cur_next.pfx_len     = '0;
          cur_next.seen_qp     = 1'b0;
          cur_next.seen_prefix = 1'b0;
          cur_next.entry_left  = b;
          if (b == '0) begin
            fmt_err = 1'b1;
          end else begin
            cur_next.phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (cur.entry_left < 8'd2) begin
            fmt_err = 1'b1;
          end else begin
            cur_next.tlv_kind   = b;
            cur_next.entry_left = entry_dec;
            cur_next.phase      = PH_TLEN;
          end
        end
        PH_TLEN: begin
          cur_next.entry_left = entry_dec;
          if (cur.tlv_kind == cfg.dqpn_type) begin
            if (b == '0 || b > BYTE_W'(MAX_QP_BITS) || val_bytes > {1'b0, entry_dec}) begin
              fmt_err = 1'b1;
            end else begin
              cur_next.tlv_bits = b[QPLEN_W-1:0];
              cur_next.tlv_left = val_bytes[BYTE_W-1:0];
              cur_next.qp_accum = '0;
              cur_next.phase    = PH_QPVAL;
            end
          end else if (cur.tlv_kind == cfg.prefix_type) begin
            if (b > BYTE_W'(PFX_MAX_BITS) || val_bytes > {1'b0, entry_dec}) begin
              fmt_err = 1'b1;
            end else begin
              cur_next.pfx_len     = b[PFXLEN_W-1:0];
              cur_next.seen_prefix = 1'b1;
              cur_next.byte_slot   = '0;
              cur_next.tlv_left    = val_bytes[BYTE_W-1:0];
              if (val_bytes == '0) begin
                tlv_end = 1'b1;
              end else begin
                cur_next.phase = PH_PFXVAL;
              end
            end
          end else begin
            if (b > entry_dec) begin
              fmt_err = 1'b1;
            end else begin
              cur_next.tlv_left = b;
              if (b == '0) begin
                tlv_end = 1'b1;
              end else begin
                cur_next.phase = PH_SKIP;
              end
            end
          end
        end
        PH_QPVAL: begin
          cur_next.entry_left = entry_dec;
          cur_next.tlv_left   = tlv_dec;
          cur_next.qp_accum   = qp_shifted;
          if (tlv_dec == '0) begin
            if (cur.tlv_bits < QPLEN_W'(MAX_QP_BITS) && qp_high != '0) begin
              fmt_err = 1'b1;
            end else begin
              cur_next.qp_len  = cur.tlv_bits;
              cur_next.seen_qp = 1'b1;
              tlv_end          = 1'b1;
            end
          end
        end
        PH_PFXVAL: begin
          cur_next.entry_left = entry_dec;
          cur_next.tlv_left   = tlv_dec;
          // slot 0 lands in the top byte of the address
          for (int k = 0; k < 4; k++) begin
            if (cur.byte_slot == 2'(k)) begin
              cur_next.prefix[PFX_W-BYTE_W-BYTE_W*k +: BYTE_W] = b;
            end
          end
          cur_next.byte_slot = cur.byte_slot + 2'd1;
          if (tlv_dec == '0) begin
            tlv_end = 1'b1;
          end
        end
        PH_SKIP: begin
          cur_next.entry_left = entry_dec;
          cur_next.tlv_left   = tlv_dec;
          if (tlv_dec == '0) begin
            tlv_end = 1'b1;
          end
        end
        default: begin
          fmt_err = 1'b1;
        end
      endcase

      if (fmt_err) begin
        emit             = 1'b1;
        code             = ST_FORMAT;
        cur_next.stopped = 1'b1;
      end else if (tlv_end) begin
        if (cur_next.entry_left == '0) begin
          cur_next.phase = PH_LEN;
          emit           = 1'b1;
          if (cur_next.seen_qp && cur_next.seen_prefix) begin
            code = ST_OK;
          end else begin
            code             = ST_FORMAT;
            cur_next.stopped = 1'b1;
          end
        end else begin
          cur_next.phase = PH_TYPE;
        end
      end
    end

    // block ended part way through an entry
    if (item.block_end && !emit && !cur_next.stopped && cur_next.phase != PH_LEN) begin
      emit = 1'b1;
      code = ST_TRUNCATED;
    end

    res.status        = code;
    res.last_of_block = item.block_end;
    if (code == ST_OK) begin
      res.qp_number   = cur_next.qp_accum;
      res.qp_bits     = cur_next.qp_len;
      res.prefix_addr = cur_next.prefix;
      res.prefix_bits = cur_next.pfx_len;
    end else begin
      res.qp_number   = '0;
      res.qp_bits     = '0;
      res.prefix_addr = '0;
      res.prefix_bits = '0;
    end

    if (item.block_end) begin
      cur_next = PSTATE_RST;
    end
  end

  assign res_valid = item_valid && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= PSTATE_RST;
    end else if (advance) begin
      cur <= cur_next;
    end
  end

endmodule

>>> rtl/qpnlri_out_stage.sv
// qpnlri_out_stage: result register with a skid entry, drives the result channel
// depends on qpnlri_pkg and qpnlri_out_if
module qpnlri_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qpnlri_pkg::res_t push_res,
  output logic             can_take,
  qpnlri_out_if.source     dst
);
  import qpnlri_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t main_res;
  res_t skid_res;
  logic pop;
  logic load_main;

  assign can_take  = !skid_valid;
  assign pop       = main_valid && dst.ready;
  assign load_main = !main_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_main) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      main_res <= skid_valid ? skid_res : push_res;
    end else if (push) begin
      skid_res <= push_res;
    end
  end

  assign dst.valid         = main_valid;
  assign dst.status        = main_res.status;
  assign dst.qp_number     = main_res.qp_number;
  assign dst.qp_bits       = main_res.qp_bits;
  assign dst.prefix_addr   = main_res.prefix_addr;
  assign dst.prefix_bits   = main_res.prefix_bits;
  assign dst.last_of_block = main_res.last_of_block;

endmodule

>>> rtl/qp_nlri_tlv_parser_core.sv
// qp_nlri_tlv_parser_core: top level of the ipv4 qp nlri tlv parser
// depends on qpnlri_pkg, qpnlri_if, qpnlri_in_stage, qpnlri_parse, qpnlri_out_stage
//
// usage:
//   byte_in carries one raw byte of the nlri block per transaction, with
//   block_end set on the final byte. result carries at most one transaction
//   per input byte: an entry (status ok), a format error (sent once, then the
//   rest of the block is dropped) or a truncation at block end.
//   wr_en/wr_index/wr_data write the dqpn and prefix tlv type codes; write
//   them only while the parser is idle.
// timing:
//   one byte per cycle sustained while result is not stalled. a result reaches
//   result by way of the input register, which holds its byte, and then the
//   result register, which the parse logic writes.
// reset:
//   rst (synchronous) empties both registers, returns the parser to the
//   entry length byte and loads type codes 1 (dqpn) and 2 (prefix).
// stalls:
//   while result is stalled the output register and its skid entry fill,
//   after which the input register holds and byte_in.ready drops. nothing
//   is lost or repeated.
module qp_nlri_tlv_parser_core (
  input  logic                                  clk,
  input  logic                                  rst,
  qpnlri_in_if.sink                             byte_in,
  qpnlri_out_if.source                          result,
  input  logic                                  wr_en,
  input  logic [qpnlri_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [qpnlri_pkg::BYTE_W-1:0]         wr_data
);
  import qpnlri_pkg::*;

  cfg_t     cfg;
  logic     item_valid;
  in_item_t item;
  logic     advance;
  logic     out_can_take;
  logic     res_valid;
  res_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dqpn_type   <= DQPN_TYPE_RST;
      cfg.prefix_type <= PREFIX_TYPE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_DQPN_TYPE:   cfg.dqpn_type   <= wr_data;
        CFG_PREFIX_TYPE: cfg.prefix_type <= wr_data;
        default: ;
      endcase
    end
  end

  assign advance = item_valid && out_can_take;

  qpnlri_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .src        (byte_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  qpnlri_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  qpnlri_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .push     (advance && res_valid),
    .push_res (res),
    .can_take (out_can_take),
    .dst      (result)
  );

endmodule

>>> verif/qp_nlri_tlv_parser_core_tb.sv
`timescale 1ns / 100ps
// testbench for qp_nlri_tlv_parser_core: directed and random nlri byte blocks, with a
// byte-level parser model predicting each result transaction and a scoreboard checking it
// depends on qpnlri_pkg, qpnlri_in_if / qpnlri_out_if and the rtl of the parser
module qp_nlri_tlv_parser_core_tb;
  import qpnlri_pkg::*;

  typedef enum logic [2:0] {
    P_LEN, P_TYPE, P_TLEN, P_QPVAL, P_PFXVAL, P_SKIP
  } parse_phase_t;

  typedef enum int {T_DQPN, T_PREFIX, T_OTHER} tlv_pick_t;

  logic clk;
  logic rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [BYTE_W-1:0]    wr_data;

  qpnlri_in_if  byte_if ();
  qpnlri_out_if res_if ();

  qp_nlri_tlv_parser_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_if),
    .result   (res_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // parser model state
  logic [7:0]   dqpn_type_cfg;
  logic [7:0]   prefix_type_cfg;
  parse_phase_t phase;
  int           entry_left;
  int           tlv_left;
  int           tlv_bits;
  logic [7:0]   tlv_kind;
  logic [1:0]   byte_slot;
  logic [23:0]  qp_acc;
  logic [4:0]   qp_len;
  logic [31:0]  pfx_acc;
  logic [5:0]   pfx_len;
  bit           seen_qp;
  bit           seen_pfx;
  bit           stopped;

  in_item_t byte_feed [$];
  res_t     expected_results [$];
  int       bytes_queued;
  int       bytes_taken;
  int       mismatches;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       in_taken;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void clear_parser();
    phase = P_LEN;
    entry_left = 0;
    tlv_left = 0;
    tlv_bits = 0;
    tlv_kind = '0;
    byte_slot = '0;
    qp_acc = '0;
    qp_len = '0;
    pfx_acc = '0;
    pfx_len = '0;
    seen_qp = 1'b0;
    seen_pfx = 1'b0;
    stopped = 1'b0;
  endfunction

  // a tlv has ended: either the entry ends too or the next tlv type follows
  function automatic bit close_tlv(output status_t s);
    s = ST_OK;
    if (entry_left == 0) begin
      phase = P_LEN;
      s = (seen_qp && seen_pfx) ? ST_OK : ST_FORMAT;
      return 1'b1;
    end
    phase = P_TYPE;
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic is_last, output res_t r);
    bit      hit;
    status_t s;
    int      n;
    hit = 1'b0;
    s = ST_OK;
    r = '0;
    n = (int'(b) + 7) >> 3;
    if (!stopped) begin
      case (phase)
        P_LEN: begin
          qp_acc = '0;
          qp_len = '0;
          pfx_acc = '0;
          pfx_len = '0;
          seen_qp = 1'b0;
          seen_pfx = 1'b0;
          entry_left = int'(b);
          if (b == 8'd0) begin
            hit = 1'b1;
            s = ST_FORMAT;
          end else begin
            phase = P_TYPE;
          end
        end
        P_TYPE: begin
          if (entry_left < 2) begin
            hit = 1'b1;
            s = ST_FORMAT;
          end else begin
            tlv_kind = b;
            entry_left--;
            phase = P_TLEN;
          end
        end
        P_TLEN: begin
          entry_left--;
          // dqpn wins when both type codes are equal
          if (tlv_kind == dqpn_type_cfg) begin
            if (b < 1 || b > MAX_QP_BITS || n > entry_left) begin
              hit = 1'b1;
              s = ST_FORMAT;
            end else begin
              tlv_bits = int'(b);
              tlv_left = n;
              qp_acc = '0;
              phase = P_QPVAL;
            end
          end else if (tlv_kind == prefix_type_cfg) begin
            if (b > PFX_MAX_BITS || n > entry_left) begin
              hit = 1'b1;
              s = ST_FORMAT;
            end else begin
              pfx_len = b[5:0];
              seen_pfx = 1'b1;
              byte_slot = '0;
              tlv_left = n;
              if (n == 0) hit = close_tlv(s);
              else phase = P_PFXVAL;
            end
          end else begin
            if (b > entry_left) begin
              hit = 1'b1;
              s = ST_FORMAT;
            end else begin
              tlv_left = int'(b);
              if (b == 8'd0) hit = close_tlv(s);
              else phase = P_SKIP;
            end
          end
        end
        P_QPVAL: begin
          entry_left--;
          tlv_left--;
          qp_acc = {qp_acc[15:0], b};
          if (tlv_left == 0) begin
            if (tlv_bits < 24 && (qp_acc >> tlv_bits) != 0) begin
              hit = 1'b1;
              s = ST_FORMAT;
            end else begin
              qp_len = tlv_bits[4:0];
              seen_qp = 1'b1;
              hit = close_tlv(s);
            end
          end
        end
        P_PFXVAL: begin
          entry_left--;
          tlv_left--;
          pfx_acc[31 - 8 * byte_slot -: 8] = b;
          byte_slot = byte_slot + 2'd1;
          if (tlv_left == 0) hit = close_tlv(s);
        end
        default: begin
          entry_left--;
          tlv_left--;
          if (tlv_left == 0) hit = close_tlv(s);
        end
      endcase
      if (hit && s == ST_FORMAT) stopped = 1'b1;
    end
    if (is_last && !hit && !stopped && phase != P_LEN) begin
      hit = 1'b1;
      s = ST_TRUNCATED;
    end
    if (hit) begin
      r.status = s;
      if (s == ST_OK) begin
        r.qp_number = qp_acc;
        r.qp_bits = qp_len;
        r.prefix_addr = pfx_acc;
        r.prefix_bits = pfx_len;
      end
      r.last_of_block = is_last;
    end
    if (is_last) clear_parser();
    return hit;
  endfunction

  task automatic feed_byte(input logic [7:0] b, input logic is_last);
    in_item_t it;
    it.data_byte = b;
    it.block_end = is_last;
    byte_feed.push_back(it);
    bytes_queued++;
  endtask

  task automatic put_tlv(ref logic [7:0] body [$], input logic [7:0] kind,
                         input logic [7:0] len_field, input int nbytes, input logic [31:0] val);
    body.push_back(kind);
    body.push_back(len_field);
    for (int i = nbytes - 1; i >= 0; i--) body.push_back(val[8 * i +: 8]);
  endtask

  task automatic build_entry(ref logic [7:0] blk [$]);
    logic [7:0] body [$];
    logic [7:0] other;
    logic [31:0] val;
    tlv_pick_t  pick;
    int         ntlv;
    int         bits;
    int         nb;
    ntlv = $urandom_range(2, 5);
    for (int i = 0; i < ntlv; i++) begin
      if (i < 2) pick = tlv_pick_t'(i);
      else pick = tlv_pick_t'($urandom_range(0, 2));
      // swap the leading pair now and then, and sometimes leave one of them out
      if (i < 2 && $urandom_range(0, 1) == 1) pick = tlv_pick_t'(1 - i);
      if (i < 2 && $urandom_range(0, 11) == 0) pick = T_OTHER;
      case (pick)
        T_DQPN: begin
          bits = ($urandom_range(0, 7) == 0) ? 24 : $urandom_range(1, 24);
          nb = (bits + 7) / 8;
          val = $urandom();
          if ($urandom_range(0, 9) != 0) val = val & ((32'h1 << bits) - 1);
          if ($urandom_range(0, 9) == 0) val = (32'h1 << bits) - 1;
          put_tlv(body, dqpn_type_cfg, bits[7:0], nb, val);
        end
        T_PREFIX: begin
          bits = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 32);
          nb = (bits + 7) / 8;
          put_tlv(body, prefix_type_cfg, bits[7:0], nb, $urandom());
        end
        default: begin
          do other = 8'($urandom_range(0, 255));
          while (other == dqpn_type_cfg || other == prefix_type_cfg);
          nb = $urandom_range(0, 4);
          put_tlv(body, other, nb[7:0], nb, $urandom());
        end
      endcase
    end
    blk.push_back(8'(body.size()));
    foreach (body[i]) blk.push_back(body[i]);
  endtask

  task automatic queue_block();
    logic [7:0] blk [$];
    int         cut;
    repeat ($urandom_range(1, 3)) build_entry(blk);
    case ($urandom_range(0, 19))
      0, 1: blk[$urandom_range(0, blk.size() - 1)] = 8'($urandom_range(0, 255));
      2, 3: begin
        // block ends inside an entry
        cut = $urandom_range(1, blk.size() - 1);
        while (blk.size() > cut) void'(blk.pop_back());
      end
      4: blk.push_back(8'h00);
      5: blk[0] = blk[0] - 8'($urandom_range(1, 3));
      6: begin
        blk.delete();
        repeat ($urandom_range(1, 12)) blk.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    foreach (blk[i]) feed_byte(blk[i], i == blk.size() - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    if (idx == CFG_DQPN_TYPE) dqpn_type_cfg = data;
    else prefix_type_cfg = data;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // wait until every byte is in and every result is out, then let the pipeline empty
  task automatic settle();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // input side: hold the byte until it is taken
  always @(negedge clk) begin
    in_item_t it;
    if (rst) begin
      byte_if.valid <= 1'b0;
    end else if (!byte_if.valid || in_taken) begin
      if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = byte_feed.pop_front();
        byte_if.valid <= 1'b1;
        byte_if.data_byte <= it.data_byte;
        byte_if.block_end <= it.block_end;
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    res_t r;
    in_taken = 1'b0;
    if (!rst && byte_if.valid && byte_if.ready) begin
      in_taken = 1'b1;
      bytes_taken++;
      if (parse_byte(byte_if.data_byte, byte_if.block_end, r)) expected_results.push_back(r);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result transaction: expected none actual status %0d",
                 $time, res_if.status);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(res_if.status));
        check_field("qp_number", 32'(want.qp_number), 32'(res_if.qp_number));
        check_field("qp_bits", 32'(want.qp_bits), 32'(res_if.qp_bits));
        check_field("prefix_addr", want.prefix_addr, res_if.prefix_addr);
        check_field("prefix_bits", 32'(want.prefix_bits), 32'(res_if.prefix_bits));
        check_field("last_of_block", 32'(want.last_of_block), 32'(res_if.last_of_block));
      end
    end
  end

  initial begin
    logic [8:0] directed [$];
    logic [7:0] dq;
    logic [7:0] pf;
    int         start;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.block_end = 1'b0;
    res_if.ready = 1'b0;
    dqpn_type_cfg = DQPN_TYPE_RST;
    prefix_type_cfg = PREFIX_TYPE_RST;
    bytes_queued = 0;
    bytes_taken = 0;
    mismatches = 0;
    in_taken = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 47;
    clear_parser();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // bit 8 marks the block end; widest dqpn and prefix, zero length entry,
    // skipped tlv with empty prefix and one-bit dqpn, truncation, lone byte at tlv start
    directed = '{9'h00B, 9'h001, 9'h018, 9'h0FF, 9'h0FF, 9'h0FF, 9'h002, 9'h020,
                 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
                 9'h100,
                 9'h008, 9'h007, 9'h001, 9'h055, 9'h002, 9'h000, 9'h001, 9'h001, 9'h101,
                 9'h004, 9'h101,
                 9'h001, 9'h105};
    foreach (directed[i]) feed_byte(directed[i][7:0], directed[i][8]);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin dq = 8'd1;   pf = 8'd2;   end
        1: begin dq = 8'd0;   pf = 8'd255; end
        2: begin dq = 8'd255; pf = 8'd0;   end
        3: begin dq = 8'd9;   pf = 8'd9;   end
        4: begin dq = 8'd200; pf = 8'd13;  end
        default: begin dq = DQPN_TYPE_RST; pf = PREFIX_TYPE_RST; end
      endcase
      write_reg(CFG_DQPN_TYPE, dq);
      write_reg(CFG_PREFIX_TYPE, pf);
      if (p < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 47;
      end else if (p < 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      start = bytes_queued;
      while (bytes_queued - start < 170) queue_block();
      settle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
